// ----- rtl/fsfe_pkg.sv -----
// ============================================================================
// fsfe_pkg
// Shared codes and the command record passed from the front end to the
// raster back end of the shape fill engine.
// ============================================================================
`default_nettype none

package fsfe_pkg;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_RECT   = 2'd2;
	localparam logic [1:0] OP_CIRCLE = 2'd3;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_RECT   = 2'd1;
	localparam logic [1:0] KIND_CIRCLE = 2'd2;

	localparam logic CFG_CANVAS_W = 1'b0;
	localparam logic CFG_CANVAS_H = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         x_lo;
		logic [7:0]         x_hi;
		logic [7:0]         y_lo;
		logic [7:0]         y_hi;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [29:0]        rr;
		logic [31:0]        color;
		logic [7:0]         row_w;
		logic               hit;
		logic [15:0]        addr;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/fsfe_if.sv -----
// ============================================================================
// fsfe_if
// Valid/ready channels of the shape fill engine: command beats in,
// read response beats out.
// ============================================================================
`default_nettype none

interface fsfe_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        size_w;
	logic [14:0]        size_h;
	logic [14:0]        radius;
	logic [31:0]        color;

	modport source (output valid, op, pos_x, pos_y, size_w, size_h, radius, color,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, size_w, size_h, radius, color,
		output ready);
endinterface

interface fsfe_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_color;
	logic        in_bounds;

	modport source (output valid, pixel_color, in_bounds, input ready);
	modport sink (input valid, pixel_color, in_bounds, output ready);
endinterface

`default_nettype wire

// ----- rtl/framebuffer_shape_fill_engine_unit.sv -----
// ============================================================================
// framebuffer_shape_fill_engine_unit
// 2D fill engine over a 32-bit frame store: read pixel, clear, rectangle and
// circle fill, all clipped to the programmed canvas.
//
// Commands arrive on the cmd channel, one beat per command; a read gives one
// rsp beat, a draw none. The user must write the canvas size registers via
// cfg_wr_en / cfg_idx / cfg_wdata only while idle; the block does not enforce it.
//
// Reset clears the canvas registers to 128 x 128 and starts a zeroing sweep
// of the frame store, one word a cycle over all MAX_WIDTH * MAX_HEIGHT words;
// commands queue up but none is executed until the sweep ends.
//
// A draw holds the back end while it walks each pixel of its clipped bounding
// box after being popped from the queue; the single write port of the frame
// store sets the one pixel a cycle pace. A read is popped only when no draw
// or earlier response is pending, then passes the read and response states
// before rsp valid rises. The front end keeps accepting into a four-entry
// queue while the back end draws or a response waits on a stalled receiver.
// ============================================================================
`default_nettype none

module framebuffer_shape_fill_engine_unit #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fsfe_cmd_if.sink         cmd,
	fsfe_rsp_if.source       rsp,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_idx,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic [7:0]     cfg_w_q, cfg_h_q;
	logic [7:0]     eff_w, eff_h;
	fsfe_pkg::cmd_t push_data, head;
	logic           push_valid, push_ready, head_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 8'd128;
			cfg_h_q <= 8'd128;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				fsfe_pkg::CFG_CANVAS_W: cfg_w_q <= cfg_wdata;
				default:                cfg_h_q <= cfg_wdata;
			endcase
		end
	end

	assign eff_w = (32'(cfg_w_q) > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : cfg_w_q;
	assign eff_h = (32'(cfg_h_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : cfg_h_q;

	fsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.canvas_w   (eff_w),
		.canvas_h   (eff_h),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	fsfe_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	fsfe_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/fsfe_front.sv -----
// ============================================================================
// fsfe_front
// Accepts command beats, clips shapes to the canvas and builds the command
// record for the back end. Empty draws are dropped here.
// ============================================================================
`default_nettype none

module fsfe_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fsfe_cmd_if.sink          cmd,
	input  wire logic [7:0]   canvas_w,
	input  wire logic [7:0]   canvas_h,
	output fsfe_pkg::cmd_t    push_data,
	output logic              push_valid,
	input  wire logic         push_ready
);

	logic               v_s1;
	fsfe_pkg::cmd_t     cmd_s1;
	fsfe_pkg::cmd_t     nc;
	logic               keep;
	logic               take;

	logic signed [17:0] px, py, wv, hv;
	logic signed [17:0] rx0, ry0, rsw, rsh;
	logic signed [17:0] rxs, rys, rxe, rye, rxe_c, rye_c;
	logic signed [17:0] rad;
	logic signed [17:0] cxs, cys, cxe, cye, cxs_c, cys_c, cxe_c, cye_c;
	logic signed [17:0] rxh, ryh;
	logic               rect_empty, circ_empty, hit;
	logic [15:0]        rd_addr;
	logic [29:0]        rr;

	assign px  = 18'(cmd.pos_x);
	assign py  = 18'(cmd.pos_y);
	assign wv  = $signed({10'd0, canvas_w});
	assign hv  = $signed({10'd0, canvas_h});
	assign rad = $signed({3'd0, cmd.radius});

	assign rx0 = (cmd.op == fsfe_pkg::OP_CLEAR) ? 18'sd0 : px;
	assign ry0 = (cmd.op == fsfe_pkg::OP_CLEAR) ? 18'sd0 : py;
	assign rsw = (cmd.op == fsfe_pkg::OP_CLEAR) ? wv : $signed({3'd0, cmd.size_w});
	assign rsh = (cmd.op == fsfe_pkg::OP_CLEAR) ? hv : $signed({3'd0, cmd.size_h});

	assign rxs   = (rx0 < 18'sd0) ? 18'sd0 : rx0;
	assign rys   = (ry0 < 18'sd0) ? 18'sd0 : ry0;
	assign rxe   = rx0 + rsw;
	assign rye   = ry0 + rsh;
	assign rxe_c = (rxe > wv) ? wv : rxe;
	assign rye_c = (rye > hv) ? hv : rye;
	assign rxh   = rxe_c - 18'sd1;
	assign ryh   = rye_c - 18'sd1;
	assign rect_empty = (rxs >= rxe_c) || (rys >= rye_c);

	assign cxs   = px - rad;
	assign cys   = py - rad;
	assign cxe   = px + rad;
	assign cye   = py + rad;
	assign cxs_c = (cxs < 18'sd0) ? 18'sd0 : cxs;
	assign cys_c = (cys < 18'sd0) ? 18'sd0 : cys;
	assign cxe_c = (cxe > wv - 18'sd1) ? wv - 18'sd1 : cxe;
	assign cye_c = (cye > hv - 18'sd1) ? hv - 18'sd1 : cye;
	assign circ_empty = (cxs_c > cxe_c) || (cys_c > cye_c);

	assign rr = 30'(cmd.radius) * 30'(cmd.radius);

	assign hit     = (px >= 18'sd0) && (px < wv) && (py >= 18'sd0) && (py < hv);
	assign rd_addr = 16'(py[7:0]) * 16'(canvas_w) + 16'(px[7:0]);

	always_comb begin
		nc       = '0;
		nc.cx    = cmd.pos_x;
		nc.cy    = cmd.pos_y;
		nc.rr    = rr;
		nc.color = cmd.color;
		nc.row_w = canvas_w;
		nc.hit   = hit;
		nc.addr  = rd_addr;
		keep     = 1'b1;
		unique case (cmd.op)
			fsfe_pkg::OP_READ: begin
				nc.kind = fsfe_pkg::KIND_READ;
			end
			fsfe_pkg::OP_CIRCLE: begin
				nc.kind = fsfe_pkg::KIND_CIRCLE;
				nc.x_lo = cxs_c[7:0];
				nc.x_hi = cxe_c[7:0];
				nc.y_lo = cys_c[7:0];
				nc.y_hi = cye_c[7:0];
				keep    = !circ_empty;
			end
			default: begin
				nc.kind = fsfe_pkg::KIND_RECT;
				nc.x_lo = rxs[7:0];
				nc.x_hi = rxh[7:0];
				nc.y_lo = rys[7:0];
				nc.y_hi = ryh[7:0];
				keep    = !rect_empty;
			end
		endcase
	end

	assign cmd.ready  = !v_s1 || push_ready;
	assign take       = cmd.valid && cmd.ready;
	assign push_valid = v_s1;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= keep;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= nc;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fsfe_cmd_fifo.sv -----
// ============================================================================
// fsfe_cmd_fifo
// Short command queue that decouples the front end from the raster back end.
// ============================================================================
`default_nettype none

module fsfe_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fsfe_pkg::cmd_t  push_data,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output fsfe_pkg::cmd_t       head,
	output logic                 head_valid,
	input  wire logic            pop
);

	fsfe_pkg::cmd_t                    entry_q [fsfe_pkg::FIFO_DEPTH];
	logic [fsfe_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [fsfe_pkg::FIFO_CNT_W-1:0]   count_q;
	logic                              do_push, do_pop;

	assign push_ready = (count_q != fsfe_pkg::FIFO_CNT_W'(fsfe_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fsfe_back.sv -----
// ============================================================================
// fsfe_back
// Raster back end: owns the frame store, sweeps it to zero after reset,
// walks the clipped box of each draw one pixel a cycle and serves reads.
// ============================================================================
`default_nettype none

module fsfe_back #(
	parameter int DEPTH = 16384
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fsfe_pkg::cmd_t  head,
	input  wire logic            head_valid,
	output logic                 pop,
	fsfe_rsp_if.source           rsp
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DRAW = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_RSP  = 3'd4;

	logic [31:0]        mem [DEPTH];

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	fsfe_pkg::cmd_t     cur_q;
	logic [7:0]         x_q, y_q;
	logic               out_valid_q;
	logic [31:0]        out_color_q;
	logic               out_hit_q;
	logic [31:0]        rd_data_q;

	logic               v_s1;
	logic [30:0]        dx2_s1, dy2_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [31:0]        color_s1;
	logic               circ_s1;
	logic [29:0]        rr_s1;

	logic signed [16:0] dx_full, dy_full;
	logic signed [15:0] dx, dy;
	logic signed [31:0] dx_sq, dy_sq;
	logic [15:0]        pix_idx;
	logic               last_px, in_disc, we;
	logic [ADDR_W-1:0]  wa;
	logic [31:0]        wd;

	assign dx_full = $signed({9'd0, x_q}) - 17'(cur_q.cx);
	assign dy_full = $signed({9'd0, y_q}) - 17'(cur_q.cy);
	assign dx      = dx_full[15:0];
	assign dy      = dy_full[15:0];
	assign dx_sq   = dx * dx;
	assign dy_sq   = dy * dy;
	assign pix_idx = 16'(y_q) * 16'(cur_q.row_w) + 16'(x_q);
	assign last_px = (x_q == cur_q.x_hi) && (y_q == cur_q.y_hi);

	assign pop = (state_q == ST_IDLE) && head_valid
		&& ((head.kind != fsfe_pkg::KIND_READ) || (!v_s1 && !out_valid_q));

	assign in_disc = !circ_s1 || ((32'(dx2_s1) + 32'(dy2_s1)) <= 32'(rr_s1));
	assign we      = (state_q == ST_CLR) || (v_s1 && in_disc);
	assign wa      = (state_q == ST_CLR) ? clr_addr_q : addr_s1;
	assign wd      = (state_q == ST_CLR) ? 32'd0 : color_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[ADDR_W'(cur_q.addr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_DRAW);
			if (state_q == ST_RSP) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= (head.kind == fsfe_pkg::KIND_READ) ? ST_RD : ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (last_px) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_RSP;
				end
				ST_RSP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			x_q   <= head.x_lo;
			y_q   <= head.y_lo;
		end else if (state_q == ST_DRAW) begin
			if (x_q == cur_q.x_hi) begin
				x_q <= cur_q.x_lo;
				y_q <= y_q + 8'd1;
			end else begin
				x_q <= x_q + 8'd1;
			end
		end
		dx2_s1   <= dx_sq[30:0];
		dy2_s1   <= dy_sq[30:0];
		addr_s1  <= ADDR_W'(pix_idx);
		color_s1 <= cur_q.color;
		circ_s1  <= (cur_q.kind == fsfe_pkg::KIND_CIRCLE);
		rr_s1    <= cur_q.rr;
		if (state_q == ST_RSP) begin
			out_color_q <= cur_q.hit ? rd_data_q : 32'd0;
			out_hit_q   <= cur_q.hit;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_color = out_color_q;
	assign rsp.in_bounds   = out_hit_q;

endmodule

`default_nettype wire

// ----- tb/sv/framebuffer_shape_fill_engine_unit_tb.sv -----
// ============================================================================
// framebuffer_shape_fill_engine_unit_tb
// Drives read, clear, rectangle and circle commands into the fill engine and
// keeps a shadow frame store at the same canvas size. Every read beat is
// checked against the shadow pixel, with clipping, canvas saturation, empty
// canvases and canvas resizing covered. Both channels stall at random.
// ============================================================================

module framebuffer_shape_fill_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W       = 128;
	localparam int MAX_H       = 128;
	localparam int STORE_WORDS = MAX_W * MAX_H;
	localparam int STALL_LIMIT = 400000;
	localparam int PHASE_ITEMS = 120;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        size_w;
		logic [14:0]        size_h;
		logic [14:0]        radius;
		logic [31:0]        color;
	} shape_cmd_t;

	typedef struct {
		logic [31:0] pixel_color;
		logic        in_bounds;
	} pixel_read_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_idx;
	logic [7:0] cfg_wdata;

	fsfe_cmd_if cmd_ch ();
	fsfe_rsp_if rsp_ch ();

	framebuffer_shape_fill_engine_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	logic [31:0] shadow_frame [STORE_WORDS];
	logic [7:0]  width_reg = 8'd128;
	logic [7:0]  height_reg = 8'd128;
	pixel_read_t pending_pixels [$];
	int          mismatch_count = 0;
	int          stall_cycles = 0;
	bit          steady = 1'b0;

	always #2 clk = ~clk;

	initial begin
		foreach (shadow_frame[i])
			shadow_frame[i] = '0;
	end

	// ------------------------------------------------------------------------
	// shadow frame store
	// ------------------------------------------------------------------------
	function automatic int canvas_w();
		return (int'(width_reg) > MAX_W) ? MAX_W : int'(width_reg);
	endfunction

	function automatic int canvas_h();
		return (int'(height_reg) > MAX_H) ? MAX_H : int'(height_reg);
	endfunction

	function automatic void paint_box(int xs, int ys, int xe, int ye, logic [31:0] color);
		int w;
		int h;
		w = canvas_w();
		h = canvas_h();
		if (xs < 0) xs = 0;
		if (ys < 0) ys = 0;
		if (xe > w) xe = w;
		if (ye > h) ye = h;
		for (int y = ys; y < ye; y++)
			for (int x = xs; x < xe; x++)
				shadow_frame[y * w + x] = color;
	endfunction

	function automatic void paint_disc(int cx, int cy, int r, logic [31:0] color);
		int w;
		int xs;
		int xe;
		int ys;
		int ye;
		longint rr;
		longint dx;
		longint dy;
		w = canvas_w();
		xs = cx - r;
		xe = cx + r;
		ys = cy - r;
		ye = cy + r;
		rr = longint'(r) * longint'(r);
		if (xs < 0) xs = 0;
		if (ys < 0) ys = 0;
		if (xe > w - 1) xe = w - 1;
		if (ye > canvas_h() - 1) ye = canvas_h() - 1;
		for (int y = ys; y <= ye; y++) begin
			dy = longint'(y) - longint'(cy);
			for (int x = xs; x <= xe; x++) begin
				dx = longint'(x) - longint'(cx);
				if (dx * dx + dy * dy <= rr)
					shadow_frame[y * w + x] = color;
			end
		end
	endfunction

	function automatic void apply_shape_cmd(shape_cmd_t c);
		pixel_read_t px;
		int x;
		int y;
		x = int'(c.pos_x);
		y = int'(c.pos_y);
		case (c.op)
			fsfe_pkg::OP_READ: begin
				px.pixel_color = '0;
				px.in_bounds = 1'b0;
				if (x >= 0 && x < canvas_w() && y >= 0 && y < canvas_h()) begin
					px.pixel_color = shadow_frame[y * canvas_w() + x];
					px.in_bounds = 1'b1;
				end
				pending_pixels.push_back(px);
			end
			fsfe_pkg::OP_CLEAR:
				paint_box(0, 0, canvas_w(), canvas_h(), c.color);
			fsfe_pkg::OP_RECT:
				paint_box(x, y, x + int'(c.size_w), y + int'(c.size_h), c.color);
			default:
				paint_disc(x, y, int'(c.radius), c.color);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic shape_cmd_t make_cmd(logic [1:0] op, int x, int y, int w, int h,
		int r, logic [31:0] color);
		shape_cmd_t c;
		c.op = op;
		c.pos_x = x[15:0];
		c.pos_y = y[15:0];
		c.size_w = w[14:0];
		c.size_h = h[14:0];
		c.radius = r[14:0];
		c.color = color;
		return c;
	endfunction

	function automatic int pick_coord(int lim);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return int'($urandom_range(0, lim + 3)) - 2;
		else if (roll < 95)
			return int'($urandom_range(0, lim + 80)) - 40;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic shape_cmd_t random_cmd();
		shape_cmd_t c;
		int roll;
		bit big;
		roll = $urandom_range(0, 99);
		big = ($urandom_range(0, 99) < 3);
		c = make_cmd(fsfe_pkg::OP_READ, pick_coord(canvas_w()), pick_coord(canvas_h()),
			$urandom_range(0, 32767), $urandom_range(0, 32767),
			$urandom_range(0, 32767), $urandom());
		if (roll < 40) begin
			c.op = fsfe_pkg::OP_READ;
		end else if (roll < 42) begin
			c.op = fsfe_pkg::OP_CLEAR;
		end else if (roll < 71) begin
			c.op = fsfe_pkg::OP_RECT;
			if (!big) begin
				c.size_w = 15'($urandom_range(0, 16));
				c.size_h = 15'($urandom_range(0, 16));
			end
		end else begin
			c.op = fsfe_pkg::OP_CIRCLE;
			if (!big)
				c.radius = 15'($urandom_range(0, 10));
		end
		return c;
	endfunction

	task automatic send_cmd(input shape_cmd_t c);
		while (!steady && $urandom_range(0, 99) < 25) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.op     <= c.op;
		cmd_ch.pos_x  <= c.pos_x;
		cmd_ch.pos_y  <= c.pos_y;
		cmd_ch.size_w <= c.size_w;
		cmd_ch.size_h <= c.size_h;
		cmd_ch.radius <= c.radius;
		cmd_ch.color  <= c.color;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		apply_shape_cmd(c);
	endtask

	task automatic read_pixel(input int x, input int y);
		send_cmd(make_cmd(fsfe_pkg::OP_READ, x, y, $urandom_range(0, 32767),
			$urandom_range(0, 32767), $urandom_range(0, 32767), $urandom()));
	endtask

	// read back once earlier draws retire, then drop valid and wait out the rest
	task automatic settle_engine();
		read_pixel(0, 0);
		cmd_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_canvas(input logic [7:0] w, input logic [7:0] h);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= fsfe_pkg::CFG_CANVAS_W;
		cfg_wdata <= w;
		@(posedge clk);
		width_reg = w;
		cfg_idx   <= fsfe_pkg::CFG_CANVAS_H;
		cfg_wdata <= h;
		@(posedge clk);
		height_reg = h;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_reset_state();
		read_pixel(127, 127);
		read_pixel(-1, 0);
		read_pixel(0, 128);
		read_pixel(-32768, 32767);
		read_pixel(32767, -32768);
		settle_engine();
	endtask

	task automatic test_clear_canvas();
		send_cmd(make_cmd(fsfe_pkg::OP_CLEAR, -32768, 32767, 32767, 32767, 32767,
			32'hFFFF_FFFF));
		read_pixel(127, 0);
		send_cmd(make_cmd(fsfe_pkg::OP_CLEAR, 5, 5, 0, 0, 0, 32'hA5A5_5A5A));
		read_pixel(0, 127);
		settle_engine();
	endtask

	task automatic test_rect_fill();
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, -3, -3, 8, 6, 0, 32'h1111_0001));
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, 10, 10, 0, 5, 0, 32'h2222_0002));
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, 10, 10, 5, 0, 0, 32'h3333_0003));
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, 120, 125, 32767, 32767, 0, 32'h4444_0004));
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, -32768, -32768, 32767, 32767, 0,
			32'h5555_0005));
		read_pixel(4, 2);
		read_pixel(5, 2);
		read_pixel(10, 10);
		read_pixel(127, 127);
		settle_engine();
	endtask

	task automatic test_circle_fill();
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, 64, 64, 0, 0, 32767, 32'h0000_00C1));
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, 20, 20, 0, 0, 0, 32'h0000_00C2));
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, -1, 5, 0, 0, 0, 32'h0000_00C3));
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, 127, 0, 0, 0, 5, 32'h0000_00C4));
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, -32768, -32768, 0, 0, 32767,
			32'h0000_00C5));
		read_pixel(20, 20);
		read_pixel(21, 20);
		read_pixel(123, 3);
		read_pixel(122, 3);
		settle_engine();
	endtask

	task automatic test_canvas_limits();
		write_canvas(8'd0, 8'd0);
		send_cmd(make_cmd(fsfe_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 32'hDEAD_0001));
		send_cmd(make_cmd(fsfe_pkg::OP_CIRCLE, 0, 0, 0, 0, 3, 32'hDEAD_0002));
		read_pixel(0, 0);
		settle_engine();
		write_canvas(8'd255, 8'd255);
		read_pixel(127, 127);
		read_pixel(128, 0);
		settle_engine();
		write_canvas(8'd1, 8'd1);
		send_cmd(make_cmd(fsfe_pkg::OP_RECT, -5, -5, 32767, 32767, 0, 32'hBEEF_0003));
		read_pixel(1, 0);
		settle_engine();
		write_canvas(8'd128, 8'd128);
		read_pixel(1, 0);
		settle_engine();
	endtask

	task automatic test_random_traffic();
		logic [7:0] w_list [10] = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd90,
			8'd128, 8'd1, 8'd7, 8'd64, 8'd33};
		logic [7:0] h_list [10] = '{8'd128, 8'd255, 8'd1, 8'd37, 8'd0,
			8'd1, 8'd128, 8'd13, 8'd100, 8'd57};
		for (int p = 0; p < 10; p++) begin
			write_canvas(w_list[p], h_list[p]);
			steady = (p == 8);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_cmd(random_cmd());
			settle_engine();
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------------
	initial rsp_ch.ready = 1'b0;

	always @(posedge clk)
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 25);

	always @(posedge clk) begin
		pixel_read_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected read beat", rsp_ch.pixel_color, '0);
			end else begin
				want = pending_pixels.pop_front();
				if (rsp_ch.pixel_color !== want.pixel_color)
					report_mismatch("pixel_color", rsp_ch.pixel_color, want.pixel_color);
				if (rsp_ch.in_bounds !== want.in_bounds)
					report_mismatch("in_bounds", 32'(rsp_ch.in_bounds), 32'(want.in_bounds));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_idx       <= fsfe_pkg::CFG_CANVAS_W;
		cfg_wdata     <= '0;
		cmd_ch.valid  <= 1'b0;
		cmd_ch.op     <= fsfe_pkg::OP_READ;
		cmd_ch.pos_x  <= '0;
		cmd_ch.pos_y  <= '0;
		cmd_ch.size_w <= '0;
		cmd_ch.size_h <= '0;
		cmd_ch.radius <= '0;
		cmd_ch.color  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_clear_canvas();
		test_rect_fill();
		test_circle_fill();
		test_canvas_limits();
		test_random_traffic();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
